// ----- hw/rtl/fqsr_pkg.sv -----
// ----------------------------------------------------------------------------
// fqsr_pkg
// Types and constants shared by the FIFO queue with search and remove.
// ----------------------------------------------------------------------------
package fqsr_pkg;

    localparam int VALUE_W = 32;
    localparam int OCC_W   = 5;

    typedef enum logic [1:0] {
        MODE_PUSH   = 2'd0,
        MODE_POP    = 2'd1,
        MODE_SEARCH = 2'd2,
        MODE_REMOVE = 2'd3
    } t_mode;

    typedef logic signed [VALUE_W-1:0] t_value;

    // Broadcast from the top level to every cell for one transfer
    typedef struct packed {
        logic   en;
        t_mode  mode;
        t_value value;
    } t_cell_ctrl;

endpackage

// ----- hw/rtl/fqsr_if.sv -----
// ----------------------------------------------------------------------------
// fqsr_in_if / fqsr_out_if
// Valid/ready channels carrying queue operations and their results.
// ----------------------------------------------------------------------------
interface fqsr_in_if import fqsr_pkg::*; ;
    logic   valid;
    logic   ready;
    t_mode  mode;
    t_value value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

interface fqsr_out_if import fqsr_pkg::*; ;
    logic             valid;
    logic             ready;
    t_value           popped_value;
    logic             hit;
    logic             overflow;
    logic [OCC_W-1:0] occupancy;

    modport source (output valid, output popped_value, output hit, output overflow,
                    output occupancy, input ready);
    modport sink   (input valid, input popped_value, input hit, input overflow,
                    input occupancy, output ready);
endinterface

// ----- hw/rtl/fqsr_cell.sv -----
// ----------------------------------------------------------------------------
// fqsr_cell
// One queue slot: holds an entry, compares it, loads on push, shifts down on
// pop, or on remove when it holds the newest match or sits above it.
// ----------------------------------------------------------------------------
module fqsr_cell import fqsr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  logic       i_prev_valid,
    input  logic       i_next_valid,
    input  t_value     i_next_data,
    input  logic       i_match_below,
    input  logic       i_match_above,
    output logic       o_valid,
    output t_value     o_data,
    output logic       o_match_below,
    output logic       o_match_above
);

    logic   r_valid;
    t_value r_data;
    logic   n_valid;
    t_value n_data;
    logic   w_match;
    logic   w_shift;

    assign w_match       = r_valid && (r_data == i_ctrl.value);
    assign o_match_below = i_match_below | w_match;
    assign o_match_above = i_match_above | w_match;

    // On remove, slots from the newest match upwards close the gap
    always_comb begin
        w_shift = 1'b0;
        n_valid = r_valid;
        n_data  = r_data;
        case (i_ctrl.mode)
            MODE_PUSH: begin
                if (!r_valid && i_prev_valid) begin
                    n_valid = 1'b1;
                    n_data  = i_ctrl.value;
                end
            end
            MODE_POP:    w_shift = 1'b1;
            MODE_SEARCH: w_shift = 1'b0;
            MODE_REMOVE: w_shift = o_match_below && !i_match_above;
            default:     w_shift = 1'b0;
        endcase
        if (w_shift) begin
            n_valid = i_next_valid;
            n_data  = i_next_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.en) begin
            r_valid <= n_valid;
        end
        if (i_ctrl.en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- hw/rtl/fifo_queue_with_search_remove.sv -----
// ----------------------------------------------------------------------------
// fifo_queue_with_search_remove
// Bounded FIFO of signed 32-bit values with push, pop, search and remove.
// ----------------------------------------------------------------------------
// The queue is a row of DEPTH slots, slot 0 holding the oldest entry. One
// operation is taken per cycle and its result appears in the output register
// on the following cycle; input ready only drops while that result is held
// back by the sink. Search and remove compare every slot at once; the
// newest-match decision ripples through the row of slots, so the clock period
// grows with DEPTH. Occupancy is reported in five bits, masked when DEPTH
// exceeds 31.
module fifo_queue_with_search_remove import fqsr_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    fqsr_in_if.sink    i_in,
    fqsr_out_if.source o_out
);

    localparam int CW = $clog2(DEPTH + 1);

    t_cell_ctrl       w_ctrl;
    logic             w_accept;
    logic [DEPTH-1:0] w_valid;
    t_value           w_data  [DEPTH];
    logic [DEPTH:0]   w_below;
    logic [DEPTH:0]   w_above;
    logic             w_full;
    logic             w_any;

    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic             r_out_valid;
    t_value           r_popped;
    logic             r_hit;
    logic             r_overflow;
    t_value           n_popped;
    logic             n_hit;
    logic             n_overflow;
    logic [CW+4:0]    w_occ_ext;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_ctrl.en    = w_accept;
    assign w_ctrl.mode  = i_in.mode;
    assign w_ctrl.value = i_in.value;

    assign w_below[0]     = 1'b0;
    assign w_above[DEPTH] = 1'b0;

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic   w_prev_valid;
        logic   w_next_valid;
        t_value w_next_data;

        if (gi == 0) begin : g_first
            assign w_prev_valid = 1'b1;
        end else begin : g_mid
            assign w_prev_valid = w_valid[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_last
            assign w_next_valid = 1'b0;
            assign w_next_data  = w_data[gi];
        end else begin : g_inner
            assign w_next_valid = w_valid[gi+1];
            assign w_next_data  = w_data[gi+1];
        end

        fqsr_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_prev_valid  (w_prev_valid),
            .i_next_valid  (w_next_valid),
            .i_next_data   (w_next_data),
            .i_match_below (w_below[gi]),
            .i_match_above (w_above[gi+1]),
            .o_valid       (w_valid[gi]),
            .o_data        (w_data[gi]),
            .o_match_below (w_below[gi+1]),
            .o_match_above (w_above[gi])
        );
    end

    assign w_full = w_valid[DEPTH-1];
    assign w_any  = w_below[DEPTH];

    always_comb begin
        n_popped   = '0;
        n_hit      = 1'b0;
        n_overflow = 1'b0;
        n_count    = r_count;
        case (i_in.mode)
            MODE_PUSH: begin
                n_hit      = !w_full;
                n_overflow = w_full;
                if (!w_full) begin
                    n_count = r_count + CW'(1);
                end
            end
            MODE_POP: begin
                n_hit = w_valid[0];
                if (w_valid[0]) begin
                    n_popped = w_data[0];
                    n_count  = r_count - CW'(1);
                end
            end
            MODE_SEARCH: n_hit = w_any;
            MODE_REMOVE: begin
                n_hit = w_any;
                if (w_any) begin
                    n_count = r_count - CW'(1);
                end
            end
            default: n_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_popped   <= n_popped;
            r_hit      <= n_hit;
            r_overflow <= n_overflow;
        end
    end

    // r_count already holds the count after the registered operation
    assign w_occ_ext = {5'b0, r_count};

    assign o_out.valid        = r_out_valid;
    assign o_out.popped_value = r_popped;
    assign o_out.hit          = r_hit;
    assign o_out.overflow     = r_overflow;
    assign o_out.occupancy    = w_occ_ext[OCC_W-1:0];

    a_count_matches_slots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CW'($countones(w_valid)))
        else $error("entry count differs from occupied slots");

    a_slots_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((({1'b0, w_valid} + 1'b1) & {1'b0, w_valid}) == '0))
        else $error("occupied slots not packed towards the head");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.mode == MODE_POP && w_valid[0])
        |=> (r_count == $past(r_count) - CW'(1)))
        else $error("pop of a non-empty queue did not shrink it");

    a_overflow_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_overflow && r_hit))
        else $error("overflow and hit reported together");

endmodule
